// ----- rtl/uer_pkg.sv -----
// uer_pkg: types and constants shared by the ultrasonic echo ranger
// no dependencies; compile first

package uer_pkg;

   // measurement phases
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIG_LOW  = 3'd1,
      PH_TRIG_HIGH = 3'd2,
      PH_WAIT_END  = 3'd3,
      PH_WAIT_RISE = 3'd4,
      PH_MEASURE   = 3'd5
   } phase_type;

   // control register indexes
   localparam logic [1:0] CSR_TIMEOUT   = 2'd0;
   localparam logic [1:0] CSR_TRIG_LOW  = 2'd1;
   localparam logic [1:0] CSR_TRIG_HIGH = 2'd2;

   localparam int unsigned CSR_DATA_BITS = 16;
   localparam int unsigned DIST_BITS     = 11;

   // register reset values
   localparam logic [15:0] TIMEOUT_RESET   = 16'd10000;
   localparam logic [7:0]  TRIG_LOW_RESET  = 8'd4;
   localparam logic [7:0]  TRIG_HIGH_RESET = 8'd10;

   // width / 58 = (width >> 1) / 29, done as multiply by ceil(2^24 / 29)
   localparam int unsigned  HALF_BITS   = 16;
   localparam logic [19:0]  DIV29_RECIP = 20'd578525;
   localparam int unsigned  DIV29_SHIFT = 24;
   // widths at or above 2048 * 58 clamp to the largest distance
   localparam int unsigned  CLAMP_BITS_MIN = 17;
   localparam logic [16:0]  CLAMP_WIDTH    = 17'd118784;
   localparam logic [10:0]  DIST_MAX       = 11'd2047;

   // one result beat
   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic                 done_res;
      logic                 timed_out;
      logic [DIST_BITS-1:0] distance_cm;
   } result_type;

endpackage

// ----- rtl/uer_req_if.sv -----
// uer_req_if: request channel of the echo ranger, one beat per tick
// depends on nothing

interface uer_req_if;
   logic valid;
   logic ready;
   logic echo_level;
   logic start_req;

   modport source (output valid, output echo_level, output start_req, input ready);
   modport sink   (input valid, input echo_level, input start_req, output ready);
endinterface

// ----- rtl/uer_rsp_if.sv -----
// uer_rsp_if: result channel of the echo ranger, one beat per tick
// depends on uer_pkg for the distance width

interface uer_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          trigger_level;
   logic                          busy_res;
   logic                          done_res;
   logic                          timed_out;
   logic [uer_pkg::DIST_BITS-1:0] distance_cm;

   modport source (output valid, output trigger_level, output busy_res,
                   output done_res, output timed_out, output distance_cm,
                   input ready);
   modport sink   (input valid, input trigger_level, input busy_res,
                   input done_res, input timed_out, input distance_cm,
                   output ready);
endinterface

// ----- rtl/ultrasonic_echo_ranger_top.sv -----
// Ultrasonic echo ranger: each request beat is one microsecond tick carrying the
// sampled echo level and a start request, and gives exactly one result beat with
// the trigger level, busy, done, timeout flag and last distance in cm (echo
// width / 58, zero after a timeout). The block takes one beat per clock: the
// phase state and counters update in one pass and the result is registered in an
// output register, and req_if.ready stays high unless that register holds a
// result the sink has not taken. The user must write the control registers through
// csr_* only while no tick is in flight; the block does not enforce this.
// depends on uer_pkg, uer_req_if, uer_rsp_if

module ultrasonic_echo_ranger_top #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   uer_req_if.sink                           req_if,
   uer_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int unsigned CMP_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam int unsigned WIDE_BITS =
      (COUNT_BITS > uer_pkg::CLAMP_BITS_MIN) ? COUNT_BITS : uer_pkg::CLAMP_BITS_MIN;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam int unsigned PROD_BITS = uer_pkg::HALF_BITS + 20;

   // control registers
   logic [15:0] timeout_ff;
   logic [7:0]  trig_low_ff;
   logic [7:0]  trig_high_ff;

   // state
   uer_pkg::phase_type       phase_ff, phase_in;
   logic [COUNT_BITS-1:0]    ticks_ff, ticks_in;
   logic [COUNT_BITS-1:0]    width_ff, width_in;
   logic [uer_pkg::DIST_BITS-1:0] dist_ff, dist_in;

   // result register
   logic                 rsp_valid_ff;
   uer_pkg::result_type  rsp_ff, rsp_in;

   logic req_accept;
   logic done_w, tmo_w;

   // helpers
   logic [COUNT_BITS-1:0] ticks_bump, width_bump;
   logic                  ticks_limit, width_limit;
   logic [COUNT_BITS-1:0] trig_low_ext, trig_high_ext;

   // distance path
   logic [WIDE_BITS-1:0]              width_wide;
   logic [uer_pkg::HALF_BITS-1:0]     width_half;
   logic [PROD_BITS-1:0]              div_prod;
   logic [uer_pkg::DIST_BITS-1:0]     dist_div;

   // handshake
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= uer_pkg::TIMEOUT_RESET;
         trig_low_ff  <= uer_pkg::TRIG_LOW_RESET;
         trig_high_ff <= uer_pkg::TRIG_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_index)
            uer_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
            uer_pkg::CSR_TRIG_LOW:  trig_low_ff  <= csr_wdata[7:0];
            uer_pkg::CSR_TRIG_HIGH: trig_high_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // saturating increments and timeout checks
   assign ticks_bump  = (ticks_ff == CNT_MAX) ? CNT_MAX : ticks_ff + CNT_ONE;
   assign width_bump  = (width_ff == CNT_MAX) ? CNT_MAX : width_ff + CNT_ONE;
   assign ticks_limit = (CMP_BITS'(ticks_bump) >= CMP_BITS'(timeout_ff)) ||
                        (ticks_bump == CNT_MAX);
   assign width_limit = (CMP_BITS'(width_ff) >= CMP_BITS'(timeout_ff)) ||
                        (width_ff == CNT_MAX);
   assign trig_low_ext  = COUNT_BITS'(trig_low_ff);
   assign trig_high_ext = COUNT_BITS'(trig_high_ff);

   // width / 58 with clamp at the 11-bit maximum
   assign width_wide = WIDE_BITS'(width_ff);
   assign width_half = width_wide[uer_pkg::HALF_BITS:1];
   assign div_prod   = PROD_BITS'(width_half) * PROD_BITS'(uer_pkg::DIV29_RECIP);
   assign dist_div   = (width_wide >= WIDE_BITS'(uer_pkg::CLAMP_WIDTH)) ? uer_pkg::DIST_MAX :
                       div_prod[uer_pkg::DIV29_SHIFT +: uer_pkg::DIST_BITS];

   // next phase, counters and result
   always_comb begin
      phase_in = phase_ff;
      ticks_in = ticks_ff;
      width_in = width_ff;
      dist_in  = dist_ff;
      done_w   = 1'b0;
      tmo_w    = 1'b0;
      case (phase_ff)
         uer_pkg::PH_TRIG_LOW: begin
            if (ticks_ff >= trig_low_ext) begin
               phase_in = uer_pkg::PH_TRIG_HIGH;
               ticks_in = CNT_ONE;
            end else begin
               ticks_in = ticks_bump;
            end
         end
         uer_pkg::PH_TRIG_HIGH: begin
            if (ticks_ff >= trig_high_ext) begin
               phase_in = uer_pkg::PH_WAIT_END;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_bump;
            end
         end
         uer_pkg::PH_WAIT_END: begin
            if (!req_if.echo_level) begin
               phase_in = uer_pkg::PH_WAIT_RISE;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_bump;
               tmo_w    = ticks_limit;
            end
         end
         uer_pkg::PH_WAIT_RISE: begin
            if (req_if.echo_level) begin
               phase_in = uer_pkg::PH_MEASURE;
               ticks_in = CNT_ONE;
               width_in = CNT_ONE;
            end else begin
               ticks_in = ticks_bump;
               tmo_w    = ticks_limit;
            end
         end
         uer_pkg::PH_MEASURE: begin
            if (!req_if.echo_level) begin
               dist_in  = dist_div;
               done_w   = 1'b1;
               phase_in = uer_pkg::PH_IDLE;
               ticks_in = '0;
            end else if (width_limit) begin
               tmo_w = 1'b1;
            end else begin
               width_in = width_bump;
               ticks_in = width_bump;
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            ticks_in = '0;
            if (req_if.start_req) begin
               width_in = '0;
               phase_in = (trig_low_ff == 8'd0) ? uer_pkg::PH_TRIG_HIGH
                                                : uer_pkg::PH_TRIG_LOW;
               ticks_in = CNT_ONE;
            end
         end
      endcase

      // any phase timeout ends the measurement with zero distance
      if (tmo_w) begin
         done_w   = 1'b1;
         dist_in  = '0;
         phase_in = uer_pkg::PH_IDLE;
         ticks_in = '0;
      end

      rsp_in.trigger_level = (phase_in == uer_pkg::PH_TRIG_HIGH);
      rsp_in.busy_res      = (phase_in != uer_pkg::PH_IDLE);
      rsp_in.done_res      = done_w;
      rsp_in.timed_out     = tmo_w;
      rsp_in.distance_cm   = dist_in;
   end

   // state update on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uer_pkg::PH_IDLE;
         ticks_ff <= '0;
         width_ff <= '0;
         dist_ff  <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         width_ff <= width_in;
         dist_ff  <= dist_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.trigger_level = rsp_ff.trigger_level;
   assign rsp_if.busy_res      = rsp_ff.busy_res;
   assign rsp_if.done_res      = rsp_ff.done_res;
   assign rsp_if.timed_out     = rsp_ff.timed_out;
   assign rsp_if.distance_cm   = rsp_ff.distance_cm;

   // checks
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(phase_ff) && $stable(width_ff) && $stable(dist_ff))
      else $error("state changed without a request beat");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res && phase_ff == uer_pkg::PH_IDLE)
      else $error("measurement ended but block still busy");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.timed_out |-> rsp_ff.distance_cm == '0 && dist_ff == '0)
      else $error("timeout beat with nonzero distance");

   a_trigger_phase: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_ff.trigger_level == (phase_ff == uer_pkg::PH_TRIG_HIGH))
      else $error("trigger level does not match phase");

   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == uer_pkg::PH_MEASURE |->
         width_ff != '0 && (CMP_BITS'(width_ff) <= CMP_BITS'(timeout_ff) || width_ff == CNT_ONE))
      else $error("echo width outside its limit");

endmodule

// ----- tb/ultrasonic_echo_ranger_monitor.sv -----
// ultrasonic_echo_ranger_monitor: watches the tick and result channels and the csr port,
// predicts each result beat of the echo ranger and compares it field by field
// depends on uer_pkg, uer_req_if, uer_rsp_if

module ultrasonic_echo_ranger_monitor (
   input  logic                              clock,
   input  logic                              reset,
   uer_req_if                                req_ch,
   uer_rsp_if                                rsp_ch,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int unsigned                       fail_count,
   output int unsigned                       pending,
   output int unsigned                       beats_checked,
   output int unsigned                       done_count,
   output int unsigned                       timeout_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNT_BITS    = 16;
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam int unsigned RANGE_DIVISOR = 58;

   // register copies
   logic [15:0] timeout_setting;
   logic [7:0]  trig_low_setting;
   logic [7:0]  trig_high_setting;

   // ranger state
   uer_pkg::phase_type               phase_now;
   logic [COUNT_BITS-1:0]            phase_count;
   logic [COUNT_BITS-1:0]            width_count;
   logic [uer_pkg::DIST_BITS-1:0]    last_range_cm;

   // results of accepted ticks, oldest first
   uer_pkg::result_type tick_outputs[$];

   // saturating counter step
   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
      return (c == COUNT_TOP) ? c : c + 1'b1;
   endfunction

   // phase limit, also hit by a saturated counter
   function automatic bit at_limit(input logic [COUNT_BITS-1:0] c);
      return (c >= timeout_setting) || (c == COUNT_TOP);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      fail_count++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // one microsecond tick of the ranger
   task automatic step_ranger(input logic echo, input logic start,
                              output uer_pkg::result_type r);
      bit          done;
      bit          tmo;
      int unsigned quot;
      done = 1'b0;
      tmo  = 1'b0;
      case (phase_now)
         uer_pkg::PH_TRIG_LOW: begin
            if (phase_count >= trig_low_setting) begin
               phase_now   = uer_pkg::PH_TRIG_HIGH;
               phase_count = COUNT_ONE;
            end else
               phase_count = count_up(phase_count);
         end
         uer_pkg::PH_TRIG_HIGH: begin
            if (phase_count >= trig_high_setting) begin
               phase_now   = uer_pkg::PH_WAIT_END;
               phase_count = '0;
            end else
               phase_count = count_up(phase_count);
         end
         uer_pkg::PH_WAIT_END: begin
            if (!echo) begin
               phase_now   = uer_pkg::PH_WAIT_RISE;
               phase_count = '0;
            end else begin
               phase_count = count_up(phase_count);
               tmo = at_limit(phase_count);
            end
         end
         uer_pkg::PH_WAIT_RISE: begin
            if (echo) begin
               phase_now   = uer_pkg::PH_MEASURE;
               phase_count = COUNT_ONE;
               width_count = COUNT_ONE;
            end else begin
               phase_count = count_up(phase_count);
               tmo = at_limit(phase_count);
            end
         end
         uer_pkg::PH_MEASURE: begin
            if (!echo) begin
               quot = width_count / RANGE_DIVISOR;
               last_range_cm = (quot > uer_pkg::DIST_MAX) ? uer_pkg::DIST_MAX
                                                          : quot[uer_pkg::DIST_BITS-1:0];
               done        = 1'b1;
               phase_now   = uer_pkg::PH_IDLE;
               phase_count = '0;
            end else if (at_limit(width_count))
               tmo = 1'b1;
            else begin
               width_count = count_up(width_count);
               phase_count = width_count;
            end
         end
         default: begin
            phase_now   = uer_pkg::PH_IDLE;
            phase_count = '0;
            if (start) begin
               width_count = '0;
               phase_now   = (trig_low_setting == 8'd0) ? uer_pkg::PH_TRIG_HIGH
                                                        : uer_pkg::PH_TRIG_LOW;
               phase_count = COUNT_ONE;
            end
         end
      endcase
      // any phase timeout ends the measurement with no distance
      if (tmo) begin
         done          = 1'b1;
         last_range_cm = '0;
         phase_now     = uer_pkg::PH_IDLE;
         phase_count   = '0;
      end
      r.trigger_level = (phase_now == uer_pkg::PH_TRIG_HIGH);
      r.busy_res      = (phase_now != uer_pkg::PH_IDLE);
      r.done_res      = done;
      r.timed_out     = tmo;
      r.distance_cm   = last_range_cm;
   endtask

   // track registers and ticks, check result beats
   always @(posedge clock) begin
      uer_pkg::result_type seen;
      uer_pkg::result_type want;
      if (reset) begin
         timeout_setting   = uer_pkg::TIMEOUT_RESET;
         trig_low_setting  = uer_pkg::TRIG_LOW_RESET;
         trig_high_setting = uer_pkg::TRIG_HIGH_RESET;
         phase_now         = uer_pkg::PH_IDLE;
         phase_count       = '0;
         width_count       = '0;
         last_range_cm     = '0;
         tick_outputs.delete();
      end else begin
         // result beat against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.trigger_level = rsp_ch.trigger_level;
            seen.busy_res      = rsp_ch.busy_res;
            seen.done_res      = rsp_ch.done_res;
            seen.timed_out     = rsp_ch.timed_out;
            seen.distance_cm   = rsp_ch.distance_cm;
            beats_checked++;
            if (tick_outputs.size() == 0)
               report_mismatch("result beat with no tick pending", 1, 0);
            else begin
               want = tick_outputs.pop_front();
               if (seen.trigger_level !== want.trigger_level)
                  report_mismatch("trigger_level", seen.trigger_level, want.trigger_level);
               if (seen.busy_res !== want.busy_res)
                  report_mismatch("busy_res", seen.busy_res, want.busy_res);
               if (seen.done_res !== want.done_res)
                  report_mismatch("done_res", seen.done_res, want.done_res);
               if (seen.timed_out !== want.timed_out)
                  report_mismatch("timed_out", seen.timed_out, want.timed_out);
               if (seen.distance_cm !== want.distance_cm)
                  report_mismatch("distance_cm", seen.distance_cm, want.distance_cm);
               if (want.done_res)
                  done_count++;
               if (want.timed_out)
                  timeout_count++;
            end
         end
         // tick beat
         if (req_ch.valid && req_ch.ready) begin
            step_ranger(req_ch.echo_level, req_ch.start_req, want);
            tick_outputs.push_back(want);
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               uer_pkg::CSR_TIMEOUT:   timeout_setting   = csr_wdata[15:0];
               uer_pkg::CSR_TRIG_LOW:  trig_low_setting  = csr_wdata[7:0];
               uer_pkg::CSR_TRIG_HIGH: trig_high_setting = csr_wdata[7:0];
               default: ;
            endcase
         end
      end
      pending = tick_outputs.size();
   end

endmodule

// ----- tb/ultrasonic_echo_ranger_top_test.sv -----
// ultrasonic_echo_ranger_top_test: drives ticks, register settings and result stalls
// into the echo ranger and gives the verdict from the monitor's counts
// depends on uer_pkg, uer_req_if, uer_rsp_if, ultrasonic_echo_ranger_monitor and the rtl

module ultrasonic_echo_ranger_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HALF_PERIOD   = 6;
   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned MAX_GAP       = 19;
   localparam int unsigned RANDOM_TICKS  = 1150;
   localparam int unsigned HOLD_AFTER    = 300;
   localparam int unsigned HOLD_CYCLES   = 250;
   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned TAIL_CYCLES   = 8;

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [1:0]                        csr_index;
   logic [uer_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   uer_req_if req_ch ();
   uer_rsp_if rsp_ch ();

   int unsigned fail_count;
   int unsigned pending_beats;
   int unsigned beats_checked;
   int unsigned done_count;
   int unsigned timeout_count;

   // stimulus bookkeeping
   bit          fast_mode;
   logic        last_busy;
   logic        flush_echo;
   int unsigned stuck_cycles;
   int unsigned ticks_sent;
   int unsigned readings_started;
   int unsigned settings_used;
   logic [15:0] cur_timeout;
   logic [7:0]  cur_low;
   logic [7:0]  cur_high;

   ultrasonic_echo_ranger_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ultrasonic_echo_ranger_monitor u_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending_beats),
      .beats_checked (beats_checked),
      .done_count    (done_count),
      .timeout_count (timeout_count)
   );

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   // busy flag of the newest result beat, used to walk a stray measurement out
   always @(posedge clock) begin
      if (reset)
         last_busy <= 1'b0;
      else if (rsp_ch.valid && rsp_ch.ready)
         last_busy <= rsp_ch.busy_res;
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stuck_cycles <= 0;
      else if (stuck_cycles == IDLE_LIMIT) begin
         $display("no beat for %0d cycles", IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end else
         stuck_cycles <= stuck_cycles + 1;
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
         if (taken == HOLD_AFTER)
            stall = HOLD_CYCLES;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         taken++;
      end
   end

   function automatic logic stray_start(input int unsigned odds);
      return (odds != 0) && ($urandom_range(1, odds) == 1);
   endfunction

   // one tick beat, after a random gap
   task automatic send_tick(input logic echo, input logic start);
      int unsigned gap;
      gap = fast_mode ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.echo_level <= echo;
      req_ch.start_req  <= start;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ticks_sent++;
   endtask

   // stop offering and wait for every result beat
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
   endtask

   // new register setting, written only with the ranger idle
   task automatic configure(input logic [15:0] t, input logic [7:0] lo, input logic [7:0] hi);
      drain();
      // a measurement left running by a stray start is ended by a toggling echo
      while (last_busy) begin
         send_tick(flush_echo, 1'b0);
         flush_echo = ~flush_echo;
         drain();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= uer_pkg::CSR_TIMEOUT;
      csr_wdata <= t;
      @(negedge clock);
      csr_index <= uer_pkg::CSR_TRIG_LOW;
      csr_wdata <= {8'($urandom), lo};
      @(negedge clock);
      csr_index <= uer_pkg::CSR_TRIG_HIGH;
      csr_wdata <= {8'($urandom), hi};
      @(negedge clock);
      csr_we <= 1'b0;
      cur_timeout = t;
      cur_low     = lo;
      cur_high    = hi;
      settings_used++;
   endtask

   // start, trigger, echo tail, gap, echo of the given width, closing low tick
   task automatic run_measurement(input int unsigned end_len, input int unsigned gap_len,
                                  input int unsigned width, input int unsigned start_odds);
      int unsigned trig_len;
      trig_len = int'(cur_low) + ((cur_high == 0) ? 1 : int'(cur_high));
      send_tick(1'($urandom), 1'b1);
      readings_started++;
      repeat (trig_len) send_tick(1'($urandom), stray_start(start_odds));
      repeat (end_len) send_tick(1'b1, stray_start(start_odds));
      repeat (gap_len) send_tick(1'b0, stray_start(start_odds));
      repeat (width) send_tick(1'b1, stray_start(start_odds));
      send_tick(1'b0, stray_start(start_odds));
   endtask

   initial begin
      int unsigned round;
      int unsigned end_len;
      int unsigned gap_len;
      int unsigned width;
      bit          limited;
      logic [15:0] t;
      logic [7:0]  lo;
      logic [7:0]  hi;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = uer_pkg::CSR_TIMEOUT;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.echo_level = 1'b0;
      req_ch.start_req  = 1'b0;
      fast_mode         = 1'b0;
      flush_echo        = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // directed: zero trigger lengths and zero timeout
      configure(16'd0, 8'd0, 8'd0);
      run_measurement(0, 1, 1, 1);   // starts while busy and on the done tick are ignored
      run_measurement(1, 0, 0, 0);   // echo still high from before: times out at once
      run_measurement(0, 1, 2, 0);   // first high tick after the rise times out
      // measuring limit: the width stops at the timeout
      configure(16'd2, 8'd1, 8'd1);
      run_measurement(0, 1, 3, 0);

      // random settings, mostly well-formed measurements with some noise
      round = 0;
      while (ticks_sent < RANDOM_TICKS) begin
         if (round == 0) begin
            t  = uer_pkg::TIMEOUT_RESET;
            lo = uer_pkg::TRIG_LOW_RESET;
            hi = uer_pkg::TRIG_HIGH_RESET;
         end else if (round == 1) begin
            t  = 16'hFFFF;
            lo = 8'hFF;
            hi = 8'hFF;
         end else begin
            case ($urandom_range(0, 9))
               0:       t = 16'd0;
               1:       t = 16'd1;
               2:       t = 16'hFFFF;
               3:       t = uer_pkg::TIMEOUT_RESET;
               default: t = 16'($urandom_range(2, 60));
            endcase
            case ($urandom_range(0, 15))
               0:       lo = 8'hFF;
               1, 2:    lo = 8'd0;
               default: lo = 8'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 15))
               0:       hi = 8'hFF;
               1, 2:    hi = 8'd0;
               3:       hi = 8'd1;
               default: hi = 8'($urandom_range(2, 6));
            endcase
         end
         round++;
         configure(t, lo, hi);
         fast_mode = ($urandom_range(0, 3) == 0);
         repeat ((lo == 8'hFF || hi == 8'hFF) ? 1 : $urandom_range(2, 5)) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: random echo and starts
               repeat ($urandom_range(1, 10)) send_tick(1'($urandom), 1'($urandom));
            end else begin
               limited = (cur_timeout <= 60);
               end_len = ($urandom_range(0, 3) == 0) ?
                         $urandom_range(1, limited ? int'(cur_timeout) + 2 : 20) : 0;
               gap_len = (limited && $urandom_range(0, 4) == 0) ?
                         $urandom_range(int'(cur_timeout), int'(cur_timeout) + 2) :
                         $urandom_range(1, 12);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: width = $urandom_range(1, 70);
                  5, 6:    width = 58 * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
                  7:       width = limited ? $urandom_range(int'(cur_timeout),
                                                            int'(cur_timeout) + 2)
                                           : $urandom_range(1, 30);
                  8:       width = 0;
                  default: width = $urandom_range(130, 180);
               endcase
               run_measurement(end_len, gap_len, width, $urandom_range(0, 1) ? 6 : 0);
            end
            repeat ($urandom_range(0, 3)) send_tick(1'($urandom), 1'b0);
         end
      end
      fast_mode = 1'b0;

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("%0d ticks over %0d register settings, %0d measurements started",
               ticks_sent, settings_used, readings_started);
      $display("%0d result beats compared, %0d measurements ended, %0d by timeout",
               beats_checked, done_count, timeout_count);
      if (fail_count == 0 && pending_beats == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/uer_pkg.sv
rtl/uer_req_if.sv
rtl/uer_rsp_if.sv
rtl/ultrasonic_echo_ranger_top.sv
tb/ultrasonic_echo_ranger_monitor.sv
tb/ultrasonic_echo_ranger_top_test.sv
